// ----- rtl/core/ppei_pkg.sv -----
// ----------------------------------------------------------------------------
// ppei_pkg: shared types and constants of the port pin edge interrupt unit
// Register indexes, the configuration bundle and the result bundle.
// ----------------------------------------------------------------------------
package ppei_pkg;

    localparam int PORT_WIDTH = 8;
    localparam int PIN_IDX_W  = $clog2(PORT_WIDTH);
    localparam int FLAGS_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [PORT_WIDTH-1:0] CHANGE_PINS = 8'hF0;

    // Flag positions in the flags word.
    localparam int FLAG_CHANGE = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENDED_MODE = 3'd0,
        REG_INPUT_DIRS    = 3'd1,
        REG_EDGE_SELECTS  = 3'd2,
        REG_INT_ENABLES   = 3'd3,
        REG_INT_PRIOS     = 3'd4,
        REG_GLOBAL_EN     = 3'd5,
        REG_CHANGE_EN     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                  extended_mode;
        logic [PORT_WIDTH-1:0] input_directions;
        logic [3:0]            edge_selects;
        logic [3:0]            interrupt_enables;
        logic [2:0]            interrupt_priorities;
        logic [1:0]            global_enables;
        logic                  change_enable;
    } t_cfg;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] port_levels;
        logic [FLAGS_W-1:0]    flags_set;
        logic                  wake;
        logic                  irq_request;
        logic                  irq_high;
    } t_result;

endpackage

// ----- rtl/core/ppei_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ppei_cfg_regs: configuration register file
// Holds the seven control registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ppei_cfg_regs
    import ppei_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_EXTENDED_MODE: n_cfg.extended_mode        = i_cfg_data[0];
                REG_INPUT_DIRS:    n_cfg.input_directions     = i_cfg_data[PORT_WIDTH-1:0];
                REG_EDGE_SELECTS:  n_cfg.edge_selects         = i_cfg_data[3:0];
                REG_INT_ENABLES:   n_cfg.interrupt_enables    = i_cfg_data[3:0];
                REG_INT_PRIOS:     n_cfg.interrupt_priorities = i_cfg_data[2:0];
                REG_GLOBAL_EN:     n_cfg.global_enables       = i_cfg_data[1:0];
                REG_CHANGE_EN:     n_cfg.change_enable        = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.extended_mode        <= 1'b0;
            r_cfg.input_directions     <= {PORT_WIDTH{1'b1}};
            r_cfg.edge_selects         <= 4'hF;
            r_cfg.interrupt_enables    <= 4'h0;
            r_cfg.interrupt_priorities <= 3'h7;
            r_cfg.global_enables       <= 2'h0;
            r_cfg.change_enable        <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ppei_eval.sv -----
// ----------------------------------------------------------------------------
// ppei_eval: pin event evaluation
// Edge match, external interrupt flags and requests, and change detect for
// one pin event against the stored port levels.
// ----------------------------------------------------------------------------
module ppei_eval
    import ppei_pkg::*;
(
    input  t_cfg                  i_cfg,
    input  logic [PORT_WIDTH-1:0] i_levels,
    input  logic [PIN_IDX_W-1:0]  i_pin_index,
    input  logic                  i_new_level,
    output t_result               o_result
);

    logic [PORT_WIDTH-1:0] mask;
    logic [PORT_WIDTH-1:0] new_levels;
    logic                  old_bit;
    logic [1:0]            low_pin;
    logic                  ext_pin;
    logic                  edge_lvl;
    logic                  match;
    logic                  gie;
    logic                  giel;
    logic [3:0]            prio_by_pin;
    logic [FLAGS_W-1:0]    flags;
    logic                  wake;
    logic                  req;
    logic                  high;

    assign mask       = PORT_WIDTH'(1) << i_pin_index;
    assign new_levels = (i_levels & ~mask) | (i_new_level ? mask : '0);
    assign old_bit    = i_levels[i_pin_index];
    assign low_pin    = i_pin_index[1:0];
    assign ext_pin    = i_cfg.extended_mode && !i_pin_index[2];
    assign gie        = i_cfg.global_enables[0];
    assign giel       = i_cfg.global_enables[1];
    // Priority bits lined up by pin number; INT0 has none.
    assign prio_by_pin = {i_cfg.interrupt_priorities, 1'b0};

    assign edge_lvl = ext_pin ? i_cfg.edge_selects[low_pin] : i_cfg.edge_selects[0];
    assign match    = (old_bit != edge_lvl) && (i_new_level == edge_lvl);

    always_comb begin
        flags = '0;
        wake  = 1'b0;
        req   = 1'b0;
        high  = 1'b0;
        if (ext_pin) begin
            if (match) begin
                flags[low_pin] = 1'b1;
                wake           = 1'b1;
                if (low_pin != 2'd0 && i_cfg.interrupt_enables[low_pin] && gie) begin
                    if (prio_by_pin[low_pin]) begin
                        req  = 1'b1;
                        high = 1'b1;
                    end else if (giel) begin
                        req = 1'b1;
                    end
                end
            end
        end else begin
            if (!i_cfg.extended_mode && i_pin_index == '0 && match) begin
                flags[0] = 1'b1;
                if (i_cfg.interrupt_enables[0] && !gie) begin
                    wake = 1'b1;
                end
            end
            // Level change on an input among the upper pins.
            if (((i_levels ^ new_levels) & i_cfg.input_directions & mask & CHANGE_PINS) != '0)
            begin
                flags[FLAG_CHANGE] = 1'b1;
                if (i_cfg.change_enable && !gie) begin
                    wake = 1'b1;
                end
            end
        end
    end

    assign o_result.port_levels = new_levels;
    assign o_result.flags_set   = flags;
    assign o_result.wake        = wake;
    assign o_result.irq_request = req;
    assign o_result.irq_high    = high;

endmodule

// ----- rtl/core/port_pin_edge_interrupt_unit.sv -----
// ----------------------------------------------------------------------------
// port_pin_edge_interrupt_unit: port pin edge and change interrupt unit
// Tracks the levels of an 8-bit port and raises external interrupt and
// change flags, wake and interrupt requests for each pin event.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  input     in         i_in_valid / o_in_ready       i_pin_index, i_new_level
//  result    out        o_out_valid / i_out_ready     o_port_levels, o_flags_set,
//                                                     o_wake, o_irq_request, o_irq_high
//  config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
//  One item per clock while the result side is not stalled: an item is held
//  in the input register, evaluated against the stored levels and then
//  lands in the result register, which drives the outputs.
//  Reset (synchronous, active low) clears the pipeline valids and the levels.
//  A stalled result holds the result register; the input register still
//  takes an item while it is empty, then stalls behind it.
// ----------------------------------------------------------------------------
module port_pin_edge_interrupt_unit
    import ppei_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIN_IDX_W-1:0]  i_pin_index,
    input  logic                  i_new_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PORT_WIDTH-1:0] o_port_levels,
    output logic [FLAGS_W-1:0]    o_flags_set,
    output logic                  o_wake,
    output logic                  o_irq_request,
    output logic                  o_irq_high
);

    t_cfg                  cfg;
    t_result               eval_result;

    logic                  r_s1_valid;
    logic [PIN_IDX_W-1:0]  r_s1_pin;
    logic                  r_s1_level;
    logic                  r_s2_valid;
    t_result               r_s2_result;
    logic [PORT_WIDTH-1:0] r_levels;

    logic                  s1_advance;
    logic                  in_accept;

    ppei_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ppei_eval u_eval (
        .i_cfg       (cfg),
        .i_levels    (r_levels),
        .i_pin_index (r_s1_pin),
        .i_new_level (r_s1_level),
        .o_result    (eval_result)
    );

    assign s1_advance = r_s1_valid && (!r_s2_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_levels   <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_s2_valid <= 1'b1;
                r_levels   <= eval_result.port_levels;
            end else if (i_out_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pin   <= i_pin_index;
            r_s1_level <= i_new_level;
        end
        if (s1_advance) begin
            r_s2_result <= eval_result;
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_port_levels = r_s2_result.port_levels;
    assign o_flags_set   = r_s2_result.flags_set;
    assign o_wake        = r_s2_result.wake;
    assign o_irq_request = r_s2_result.irq_request;
    assign o_irq_high    = r_s2_result.irq_high;

    // The stored levels always match the most recent result.
    a_levels_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> (r_levels == o_port_levels))
        else $error("stored levels differ from last result");

    // The high vector is only reported alongside a request.
    a_high_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_high) |-> o_irq_request)
        else $error("high vector without request");

    // A request always comes from one of INT1-INT3.
    a_req_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_request) |-> $onehot(o_flags_set[3:1]) && o_wake)
        else $error("request without an INT1-INT3 flag");

    // Change detect and an external request never come from the same item.
    a_change_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_flags_set[FLAG_CHANGE]) |-> !o_irq_request)
        else $error("change flag together with a request");

    // The input side only stalls when the input register holds an item.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s2_valid))
        else $error("input stalled without a held item");

endmodule
